### sv/spsf_pkg.sv
// Package for the stationary point scan filter.
// Holds field widths, reset values and the command type passed from the front to the back.
// No dependencies.
package spsf_pkg;

	localparam int POS_W     = 32;
	localparam int SMP_W     = 32;
	localparam int IDX_W     = 16;
	localparam int THR_W     = 31;
	localparam int DIFF_W    = POS_W + 1;
	localparam logic [THR_W-1:0] THR_RESET = 31'd66;

	localparam int SLOTS     = 3;
	localparam int SLOT_W    = 2;
	localparam int CQ_DEPTH  = 4;
	localparam int CQ_AW     = 2;

	typedef struct packed {
		logic                        triple;
		logic [SLOTS-1:0][POS_W-1:0] pos;
		logic [SLOTS-1:0][SMP_W-1:0] smp;
		logic [SLOTS-1:0][IDX_W-1:0] idx;
	} cmd_t;

endpackage

### sv/spsf_front.sv
// Front part of the stationary point scan filter: accepts points and classifies them.
// Keeps the previous position, moving run, held points and kept count; issues commands.
// Depends on spsf_pkg.
module spsf_front #(
	parameter int          CONFIRM_RUN = 3,
	parameter int unsigned IDX_CAP     = 65535
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              threshold_we,
	input  logic [spsf_pkg::THR_W-1:0]        threshold_wdata,
	input  logic                              push,
	input  logic signed [spsf_pkg::POS_W-1:0] axis_position,
	input  logic signed [spsf_pkg::SMP_W-1:0] sample_value,
	input  logic                              scan_start,
	output logic                              full,
	output logic                              cq_push,
	input  logic                              cq_full,
	output spsf_pkg::cmd_t                    cq_data
);

	localparam int RUN_W = $clog2(CONFIRM_RUN + 2);
	localparam int IW    = spsf_pkg::IDX_W;
	localparam int PW    = spsf_pkg::POS_W;
	localparam int SW    = spsf_pkg::SMP_W;
	localparam int DW    = spsf_pkg::DIFF_W;
	localparam logic [RUN_W-1:0] RUN_CONFIRM = RUN_W'(CONFIRM_RUN);
	localparam logic [RUN_W-1:0] RUN_LIMIT   = RUN_W'(CONFIRM_RUN + 1);
	localparam logic [IW-1:0]    CAP         = IW'(IDX_CAP);

	logic [spsf_pkg::THR_W-1:0] thr_q;
	logic [PW-1:0]              prev_q;
	logic [RUN_W-1:0]           run_q;
	logic [IW-1:0]              count_q;
	logic [1:0][PW-1:0]         held_pos_q;
	logic [1:0][SW-1:0]         held_smp_q;

	logic                       valid_s1;
	logic [PW-1:0]              pos_s1;
	logic [SW-1:0]              smp_s1;
	logic                       start_s1;
	logic [DW-1:0]              diff_s1;

	logic                       accept;
	logic                       fire;
	logic                       stationary;
	logic                       hold;
	logic                       emit;
	logic                       triple;
	logic [DW-1:0]              thr_ext;
	logic [DW-1:0]              thr_neg;
	logic [DW-1:0]              diff_in;
	logic [IW-1:0]              idx1;
	logic [IW-1:0]              idx2;
	logic [IW-1:0]              idx_last;

	function automatic logic [IW-1:0] sat_inc(input logic [IW-1:0] c);
		sat_inc = (c < CAP) ? c + IW'(1) : c;
	endfunction

	assign accept  = push && !full;
	assign diff_in = {axis_position[PW-1], axis_position} - {prev_q[PW-1], prev_q};

	assign thr_ext    = {{(DW - spsf_pkg::THR_W){1'b0}}, thr_q};
	assign thr_neg    = -thr_ext;
	assign stationary = ($signed(diff_s1) < $signed(thr_ext)) &&
	                    ($signed(diff_s1) > $signed(thr_neg));

	assign hold   = valid_s1 && !start_s1 && !stationary && (run_q < RUN_CONFIRM);
	assign emit   = valid_s1 && !start_s1 && !stationary && (run_q >= RUN_CONFIRM);
	assign triple = (run_q == RUN_CONFIRM);
	assign fire   = valid_s1 && (!emit || !cq_full);
	assign full   = valid_s1 && !fire;

	assign idx1     = sat_inc(count_q);
	assign idx2     = sat_inc(idx1);
	assign idx_last = triple ? idx2 : count_q;

	assign cq_push        = emit && !cq_full;
	assign cq_data.triple = triple;
	assign cq_data.pos    = {pos_s1, held_pos_q[1], held_pos_q[0]};
	assign cq_data.smp    = {smp_s1, held_smp_q[1], held_smp_q[0]};
	assign cq_data.idx    = {idx_last, idx1, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= spsf_pkg::THR_RESET;
		end else if (threshold_we) begin
			thr_q <= threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= '0;
		end else begin
			if (!valid_s1 || fire) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				prev_q <= axis_position;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1   <= axis_position;
			smp_s1   <= sample_value;
			start_s1 <= scan_start;
			diff_s1  <= diff_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			count_q <= '0;
		end else if (fire) begin
			if (start_s1) begin
				run_q   <= '0;
				count_q <= '0;
			end else if (stationary) begin
				run_q <= '0;
			end else if (run_q < RUN_CONFIRM) begin
				run_q <= run_q + RUN_W'(1);
			end else begin
				if (triple) begin
					run_q <= run_q + RUN_W'(1);
				end
				count_q <= sat_inc(idx_last);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hold) begin
			held_pos_q[0] <= held_pos_q[1];
			held_smp_q[0] <= held_smp_q[1];
			held_pos_q[1] <= pos_s1;
			held_smp_q[1] <= smp_s1;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> !cq_full)
		else $error("Command pushed into a full queue.");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_LIMIT)
		else $error("Moving run counted past its limit.");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("Kept count passed its saturation value.");

endmodule

### sv/spsf_cmd_fifo.sv
// Command queue between the front and back parts of the stationary point scan filter.
// A small register file with read and write pointers and an occupancy count.
// Depends on spsf_pkg.
module spsf_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spsf_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output spsf_pkg::cmd_t rdata
);

	localparam int AW = spsf_pkg::CQ_AW;

	spsf_pkg::cmd_t mem_q [spsf_pkg::CQ_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW + 1)'(spsf_pkg::CQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

endmodule

### sv/spsf_back.sv
// Back part of the stationary point scan filter: expands commands into results.
// Walks a three-point command one slot per cycle while the output is free; holds the output register.
// Depends on spsf_pkg.
module spsf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cq_empty,
	input  spsf_pkg::cmd_t                    cq_rdata,
	output logic                              cq_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic signed [spsf_pkg::POS_W-1:0] kept_position,
	output logic signed [spsf_pkg::SMP_W-1:0] kept_sample,
	output logic [spsf_pkg::IDX_W-1:0]        kept_index,
	output logic                              last_of_burst
);

	localparam int SLW = spsf_pkg::SLOT_W;
	localparam logic [SLW-1:0] SLOT_LAST = SLW'(spsf_pkg::SLOTS - 1);

	logic [SLW-1:0]               phase_q;
	logic                         out_valid_q;
	logic [spsf_pkg::POS_W-1:0]   pos_q;
	logic [spsf_pkg::SMP_W-1:0]   smp_q;
	logic [spsf_pkg::IDX_W-1:0]   idx_q;
	logic                         last_q;

	logic [SLW-1:0]               slot;
	logic                         slot_last;
	logic                         load;

	assign slot      = cq_rdata.triple ? phase_q : SLOT_LAST;
	assign slot_last = (slot == SLOT_LAST);
	assign load      = !cq_empty && (!out_valid_q || pop);
	assign cq_pop    = load && slot_last;

	assign empty         = !out_valid_q;
	assign kept_position = $signed(pos_q);
	assign kept_sample   = $signed(smp_q);
	assign kept_index    = idx_q;
	assign last_of_burst = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= slot_last ? '0 : phase_q + SLW'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_q  <= cq_rdata.pos[slot];
			smp_q  <= cq_rdata.smp[slot];
			idx_q  <= cq_rdata.idx[slot];
			last_q <= slot_last;
		end
	end

	a_phase_in_triple: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) |-> (!cq_empty && cq_rdata.triple))
		else $error("Burst phase advanced without a three-point command at the head.");

	a_phase_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= SLOT_LAST)
		else $error("Burst phase ran past the last slot.");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("Command popped from an empty queue.");

endmodule

### sv/stationary_point_scan_filter_core.sv
// Top level of the stationary point scan filter.
// Connects the front classifier, the command queue and the back expander.
// Depends on spsf_pkg, spsf_front, spsf_cmd_fifo and spsf_back.
//
// Input channel: a scan point is accepted on a rising edge with push high and full low.
// Result channel: while empty is low the oldest kept point is on the result ports; it is
// taken on a rising edge with pop high. last_of_burst marks the final result of one input.
// Configuration: threshold_we writes threshold_wdata into the motion threshold at once;
// write it only while the block is idle.
// Path: a kept point passes the classify register, command queue and output register.
// Throughput: one point per cycle in while full is low; one result per cycle out on pop.
// The confirming point of a moving stretch yields three results from one command entry;
// the four-entry command queue absorbs further commands while input continues.
// When the receiver stalls, the output register holds, the queue fills, and full rises
// once the queue is full and the classify stage holds a point that must be kept.
// Reset clears the previous position, moving run, kept count, queue and output valid,
// and sets the threshold to its default; held points are not cleared.
module stationary_point_scan_filter_core #(
	parameter int CONFIRM_RUN = 3,
	parameter int MAX_POINTS  = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              threshold_we,
	input  logic [spsf_pkg::THR_W-1:0]        threshold_wdata,
	input  logic                              push,
	output logic                              full,
	input  logic signed [spsf_pkg::POS_W-1:0] axis_position,
	input  logic signed [spsf_pkg::SMP_W-1:0] sample_value,
	input  logic                              scan_start,
	input  logic                              pop,
	output logic                              empty,
	output logic signed [spsf_pkg::POS_W-1:0] kept_position,
	output logic signed [spsf_pkg::SMP_W-1:0] kept_sample,
	output logic [spsf_pkg::IDX_W-1:0]        kept_index,
	output logic                              last_of_burst
);

	localparam int unsigned IDX_MAX = (1 << spsf_pkg::IDX_W) - 1;
	localparam int unsigned IDX_CAP = (MAX_POINTS - 1 > IDX_MAX) ? IDX_MAX : MAX_POINTS - 1;

	logic           cq_push;
	logic           cq_full;
	logic           cq_pop;
	logic           cq_empty;
	spsf_pkg::cmd_t cq_wdata;
	spsf_pkg::cmd_t cq_rdata;

	spsf_front #(
		.CONFIRM_RUN (CONFIRM_RUN),
		.IDX_CAP     (IDX_CAP)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata),
		.push            (push),
		.axis_position   (axis_position),
		.sample_value    (sample_value),
		.scan_start      (scan_start),
		.full            (full),
		.cq_push         (cq_push),
		.cq_full         (cq_full),
		.cq_data         (cq_wdata)
	);

	spsf_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.full   (cq_full),
		.pop    (cq_pop),
		.empty  (cq_empty),
		.rdata  (cq_rdata)
	);

	spsf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cq_empty      (cq_empty),
		.cq_rdata      (cq_rdata),
		.cq_pop        (cq_pop),
		.pop           (pop),
		.empty         (empty),
		.kept_position (kept_position),
		.kept_sample   (kept_sample),
		.kept_index    (kept_index),
		.last_of_burst (last_of_burst)
	);

endmodule
